// ===== rtl/cpu_alu_execute_8bit_defines.svh =====
// Assertion macros for the accumulator execute block.
// Included by the top level; depends on nothing else.
`ifndef CPU_ALU_EXECUTE_8BIT_DEFINES_SVH
`define CPU_ALU_EXECUTE_8BIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CAE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("execute block assertion failed");
`define CAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("execute block assertion failed");
`else
`define CAE_ASSERT_NOW(label, clk, rst, ante, cons)
`define CAE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cae_pkg.sv =====
// Types and constants shared by the accumulator execute block.
// Used by cae_alu and cpu_alu_execute_8bit; depends on nothing.
`default_nettype none

package cae_pkg;

   typedef enum logic [2:0] {
      OP_ADC     = 3'd0,
      OP_AND     = 3'd1,
      OP_ASL_ACC = 3'd2,
      OP_ASL_MEM = 3'd3,
      OP_CLC     = 3'd4,
      OP_CLD     = 3'd5,
      OP_CLI     = 3'd6,
      OP_CLV     = 3'd7
   } op_type;

   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] ACC_RESET    = 8'h00;

   typedef struct packed {
      op_type     op;
      logic [7:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [7:0] acc_out;
      logic [7:0] status_out;
      logic [7:0] mem_value;
      logic       mem_write;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/cae_alu.sv =====
// Combinational execute logic: ADC, AND, ASL and the flag clears.
// Depends on cae_pkg for the operation codes, flag positions and beat types.
`default_nettype none

module cae_alu (
   input  cae_pkg::req_type req,
   input  logic [7:0]       acc,
   input  logic [7:0]       status,
   output cae_pkg::rsp_type rsp
);

   logic [8:0] sum;
   logic [7:0] result;
   logic [7:0] shifted;

   assign sum     = {1'b0, acc} + {1'b0, req.operand_value} + {8'd0, status[cae_pkg::FLAG_C]};
   assign shifted = (req.op == cae_pkg::OP_ASL_MEM) ? {req.operand_value[6:0], 1'b0}
                                                    : {acc[6:0], 1'b0};

   always_comb begin
      rsp.acc_out    = acc;
      rsp.status_out = status;
      rsp.mem_value  = 8'd0;
      rsp.mem_write  = 1'b0;
      result         = 8'd0;
      unique case (req.op)
         cae_pkg::OP_ADC: begin
            result = sum[7:0];
            rsp.acc_out = result;
            rsp.status_out[cae_pkg::FLAG_C] = sum[8];
            rsp.status_out[cae_pkg::FLAG_V] = (acc[7] ^ result[7]) &
                                              (req.operand_value[7] ^ result[7]);
         end
         cae_pkg::OP_AND: begin
            result = acc & req.operand_value;
            rsp.acc_out = result;
         end
         cae_pkg::OP_ASL_ACC: begin
            result = shifted;
            rsp.acc_out = result;
            rsp.status_out[cae_pkg::FLAG_C] = acc[7];
         end
         cae_pkg::OP_ASL_MEM: begin
            result = shifted;
            rsp.mem_value = result;
            rsp.mem_write = 1'b1;
            rsp.status_out[cae_pkg::FLAG_C] = req.operand_value[7];
         end
         cae_pkg::OP_CLC: rsp.status_out[cae_pkg::FLAG_C] = 1'b0;
         cae_pkg::OP_CLD: rsp.status_out[cae_pkg::FLAG_D] = 1'b0;
         cae_pkg::OP_CLI: rsp.status_out[cae_pkg::FLAG_I] = 1'b0;
         cae_pkg::OP_CLV: rsp.status_out[cae_pkg::FLAG_V] = 1'b0;
         default: rsp.mem_write = 1'b0;
      endcase
      if ((req.op == cae_pkg::OP_ADC) || (req.op == cae_pkg::OP_AND) ||
          (req.op == cae_pkg::OP_ASL_ACC) || (req.op == cae_pkg::OP_ASL_MEM)) begin
         rsp.status_out[cae_pkg::FLAG_Z] = (result == 8'd0);
         rsp.status_out[cae_pkg::FLAG_N] = result[7];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cpu_alu_execute_8bit.sv =====
// Execute stage of an 8-bit accumulator processor: top level.
// Depends on cae_pkg, cae_alu and cpu_alu_execute_8bit_defines.svh.
//
// Each request beat carries a decoded operation and its fetched operand
// byte. The block holds the accumulator and the status register and
// returns one response beat per request with the accumulator and status
// after the instruction, plus the shifted byte and a write strobe for a
// shift of a memory byte.
// A request beat lands in an input register; it is then executed against
// the accumulator and status and loaded into the result register, which
// drives the response. One beat per cycle is sustained while the
// receiver does not stall, set by the single 8-bit add and flag logic
// on the accumulator loop.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more request; only when both are full
// does req_stall rise.
// Synchronous reset clears both valid bits, sets the accumulator to zero
// and the status register to 0x24 (interrupt disable and bit 5 set).
`default_nettype none
`include "cpu_alu_execute_8bit_defines.svh"

module cpu_alu_execute_8bit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cae_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   cae_pkg::req_type in_data_ff;
   logic             out_valid_ff, out_valid_in;
   cae_pkg::rsp_type out_data_ff;
   logic [7:0]       acc_ff;
   logic [7:0]       status_ff;
   cae_pkg::rsp_type alu_rsp;
   logic             out_load;
   logic             in_load;

   cae_alu u_alu (
      .req    (in_data_ff),
      .acc    (acc_ff),
      .status (status_ff),
      .rsp    (alu_rsp)
   );

   assign out_load     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !out_load;
   assign in_load      = req_valid && !req_stall;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= cae_pkg::ACC_RESET;
         status_ff    <= cae_pkg::STATUS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            acc_ff    <= alu_rsp.acc_out;
            status_ff <= alu_rsp.status_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `CAE_ASSERT_NOW(a_status_spare_bits, clock, reset, 1'b1, status_ff[5:4] == 2'b10)
   `CAE_ASSERT_NOW(a_mem_value_zero, clock, reset, out_valid_ff,
                   out_data_ff.mem_write || (out_data_ff.mem_value == 8'd0))
   `CAE_ASSERT_NEXT(a_pending_advances, clock, reset,
                    out_valid_ff && !rsp_stall && in_valid_ff, out_valid_ff)
   `CAE_ASSERT_NEXT(a_state_matches_rsp, clock, reset, out_load,
                    (acc_ff == out_data_ff.acc_out) && (status_ff == out_data_ff.status_out))

endmodule

`default_nettype wire

// ===== verif/cpu_alu_execute_8bit_tb.sv =====
// Self-checking testbench for the 8-bit accumulator execute stage.
// Depends on cae_pkg and cpu_alu_execute_8bit; drives directed and random beats
// with random idling on both channels and checks every response beat.
module cpu_alu_execute_8bit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned RANDOM_BEATS = 400;
   localparam int unsigned SEGMENT_BEATS = 50;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cae_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cae_pkg::rsp_type rsp_data;

   logic [7:0]       acc_model = cae_pkg::ACC_RESET;
   logic [7:0]       flags_model = cae_pkg::STATUS_RESET;
   cae_pkg::rsp_type results_due[$];
   bit               req_gaps = 1'b1;
   bit               rsp_gaps = 1'b1;
   int unsigned      stall_left = 0;
   int unsigned      errors = 0;
   int unsigned      beats_in = 0;
   int unsigned      results_seen = 0;
   int unsigned      op_count[8];

   cpu_alu_execute_8bit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 30);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic cae_pkg::rsp_type execute_instr(input cae_pkg::req_type beat);
      cae_pkg::rsp_type res;
      logic [8:0]       sum;
      logic [7:0]       r;
      bit               touch_nz;
      res = '0;
      sum = '0;
      r = '0;
      touch_nz = 1'b1;
      case (beat.op)
         cae_pkg::OP_ADC: begin
            sum = {1'b0, acc_model} + {1'b0, beat.operand_value}
                  + {8'd0, flags_model[cae_pkg::FLAG_C]};
            r = sum[7:0];
            flags_model[cae_pkg::FLAG_C] = sum[8];
            flags_model[cae_pkg::FLAG_V] = (acc_model[7] ^ r[7])
                                           & (beat.operand_value[7] ^ r[7]);
            acc_model = r;
         end
         cae_pkg::OP_AND: begin
            acc_model = acc_model & beat.operand_value;
            r = acc_model;
         end
         cae_pkg::OP_ASL_ACC: begin
            flags_model[cae_pkg::FLAG_C] = acc_model[7];
            r = {acc_model[6:0], 1'b0};
            acc_model = r;
         end
         cae_pkg::OP_ASL_MEM: begin
            flags_model[cae_pkg::FLAG_C] = beat.operand_value[7];
            r = {beat.operand_value[6:0], 1'b0};
            res.mem_value = r;
            res.mem_write = 1'b1;
         end
         cae_pkg::OP_CLC: begin
            flags_model[cae_pkg::FLAG_C] = 1'b0;
            touch_nz = 1'b0;
         end
         cae_pkg::OP_CLD: begin
            flags_model[cae_pkg::FLAG_D] = 1'b0;
            touch_nz = 1'b0;
         end
         cae_pkg::OP_CLI: begin
            flags_model[cae_pkg::FLAG_I] = 1'b0;
            touch_nz = 1'b0;
         end
         cae_pkg::OP_CLV: begin
            flags_model[cae_pkg::FLAG_V] = 1'b0;
            touch_nz = 1'b0;
         end
      endcase
      if (touch_nz) begin
         flags_model[cae_pkg::FLAG_Z] = (r == 8'd0);
         flags_model[cae_pkg::FLAG_N] = r[7];
      end
      res.acc_out = acc_model;
      res.status_out = flags_model;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %02h, actual %02h", name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      cae_pkg::rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (results_due.size() == 0) begin
            $error("Response beat %h arrived with nothing expected.", rsp_data);
            errors++;
         end else begin
            due = results_due.pop_front();
            check_field("acc_out", due.acc_out, rsp_data.acc_out);
            check_field("status_out", due.status_out, rsp_data.status_out);
            check_field("mem_value", due.mem_value, rsp_data.mem_value);
            check_field("mem_write", {7'd0, due.mem_write}, {7'd0, rsp_data.mem_write});
         end
      end
      if (!reset && req_valid && !req_stall) begin
         results_due.push_back(execute_instr(req_data));
         beats_in++;
         op_count[req_data.op]++;
      end
   end

   always @(posedge clock) begin
      if (reset || !rsp_gaps) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= gap_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic idle_req(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_beat(input cae_pkg::op_type op, input logic [7:0] operand);
      cae_pkg::req_type beat;
      if (req_gaps && $urandom_range(0, 2) == 0) begin
         idle_req(gap_len());
      end
      beat.op = op;
      beat.operand_value = operand;
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      idle_req(1);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_adc_carry_overflow();
      send_beat(cae_pkg::OP_ADC, 8'h00);
      send_beat(cae_pkg::OP_ADC, 8'h7F);
      send_beat(cae_pkg::OP_ADC, 8'h01);
      send_beat(cae_pkg::OP_ADC, 8'hFF);
      send_beat(cae_pkg::OP_ADC, 8'h00);
      send_beat(cae_pkg::OP_ADC, 8'h80);
      send_beat(cae_pkg::OP_ADC, 8'hFF);
   endtask

   task automatic test_and_shift();
      send_beat(cae_pkg::OP_ADC, 8'hC3);
      send_beat(cae_pkg::OP_AND, 8'hFF);
      send_beat(cae_pkg::OP_ASL_ACC, 8'($urandom_range(0, 255)));
      send_beat(cae_pkg::OP_AND, 8'h00);
      send_beat(cae_pkg::OP_ASL_ACC, 8'hFF);
      send_beat(cae_pkg::OP_ASL_MEM, 8'h80);
      send_beat(cae_pkg::OP_ASL_MEM, 8'h01);
      send_beat(cae_pkg::OP_ASL_MEM, 8'hFF);
      send_beat(cae_pkg::OP_ASL_MEM, 8'h40);
   endtask

   task automatic test_flag_clears();
      send_beat(cae_pkg::OP_ADC, 8'h7F);
      send_beat(cae_pkg::OP_ADC, 8'h01);
      send_beat(cae_pkg::OP_CLV, 8'($urandom_range(0, 255)));
      send_beat(cae_pkg::OP_CLC, 8'($urandom_range(0, 255)));
      send_beat(cae_pkg::OP_CLD, 8'($urandom_range(0, 255)));
      send_beat(cae_pkg::OP_CLI, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_stream();
      logic [7:0] corners[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      logic [7:0] operand;
      for (int seg = 0; seg < RANDOM_BEATS / SEGMENT_BEATS; seg++) begin
         req_gaps = (seg % 3 == 0);
         rsp_gaps = (seg % 3 != 1);
         for (int n = 0; n < SEGMENT_BEATS; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               operand = corners[$urandom_range(0, 3)];
            end else begin
               operand = 8'($urandom_range(0, 255));
            end
            send_beat(cae_pkg::op_type'($urandom_range(0, 7)), operand);
         end
         if (seg == 2 || seg == 5) begin
            drain_results();
         end
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_adc_carry_overflow();
      test_and_shift();
      test_flag_clears();
      drain_results();
      test_random_stream();
      drain_results();
      repeat (4) @(posedge clock);
      $display("Checked %0d response beats against %0d request beats.",
               results_seen, beats_in);
      $display("Mix: adc %0d, and %0d, shift acc %0d, shift mem %0d, flag clears %0d.",
               op_count[cae_pkg::OP_ADC], op_count[cae_pkg::OP_AND],
               op_count[cae_pkg::OP_ASL_ACC], op_count[cae_pkg::OP_ASL_MEM],
               op_count[cae_pkg::OP_CLC] + op_count[cae_pkg::OP_CLD]
               + op_count[cae_pkg::OP_CLI] + op_count[cae_pkg::OP_CLV]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cae_pkg.sv
rtl/cae_alu.sv
rtl/cpu_alu_execute_8bit.sv
verif/cpu_alu_execute_8bit_tb.sv
